// ===== hw/rtl/ild_pkg.sv =====
package ild_pkg;

    // Bytes in the decode window that the lanes look at (2 to 15).
    localparam int WINDOW_BYTES = 15;

    // Bytes carried by the input ports, fixed by the field widths.
    localparam int PORT_BYTES = 15;

    // Width of a window count, and of a position that may run past the window.
    localparam int WIN_W = 4;
    localparam int POS_W = 6;
    localparam int LEN_W = 5;

    // Legacy prefixes.
    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] PFX_REPNE  = 8'hF2;
    localparam logic [7:0] PFX_REP    = 8'hF3;
    localparam logic [7:0] PFX_ES     = 8'h26;
    localparam logic [7:0] PFX_CS     = 8'h2E;
    localparam logic [7:0] PFX_SS     = 8'h36;
    localparam logic [7:0] PFX_DS     = 8'h3E;
    localparam logic [7:0] PFX_FS     = 8'h64;
    localparam logic [7:0] PFX_GS     = 8'h65;

    // REX and the opcode families; only the high bits of a family base are compared.
    localparam logic [7:0] REX_BASE    = 8'h40;
    localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
    localparam logic [7:0] OP_PUSH_POP = 8'h50;
    localparam logic [7:0] OP_JCC8     = 8'h70;

    localparam logic [7:0] OP_ESCAPE = 8'h0F;
    localparam logic [7:0] OP_MOV_C6 = 8'hC6;
    localparam logic [7:0] OP_CALL   = 8'hE8;
    localparam logic [7:0] OP_JMP32  = 8'hE9;
    localparam logic [7:0] OP_JMP8   = 8'hEB;
    localparam logic [7:0] OP_RET    = 8'hC3;
    localparam logic [7:0] OP_RETF   = 8'hCB;
    localparam logic [7:0] OP_INT3   = 8'hCC;
    localparam logic [7:0] OP_NOP    = 8'h90;
    localparam logic [7:0] OP_IMUL32 = 8'h69;
    localparam logic [7:0] OP_IMUL8  = 8'h6B;
    localparam logic [7:0] OP_GRP32  = 8'h81;
    localparam logic [7:0] OP_GRP8   = 8'h83;
    localparam logic [7:0] OP_MOV_C7 = 8'hC7;

    // ModRM field codes that change the operand span.
    localparam logic [1:0] MOD_INDIRECT = 2'd0;
    localparam logic [1:0] MOD_DISP8    = 2'd1;
    localparam logic [1:0] MOD_DISP32   = 2'd2;
    localparam logic [1:0] MOD_REG      = 2'd3;
    localparam logic [2:0] RM_SIB       = 3'd4;
    localparam logic [2:0] RM_DISP32    = 3'd5;

    // What one lane learns about its byte, for every role the byte may play.
    typedef struct packed {
        logic       pfx;       // legacy prefix
        logic       rex;       // REX byte
        logic       esc;       // 0F escape
        logic       fast;      // one-byte opcode with a fixed length
        logic       c6;        // C6: ModRM plus imm8
        logic [2:0] fast_add;  // bytes after the opcode on a fast path
        logic [2:0] imm_add;   // immediate bytes on the general path
        logic [2:0] span;      // ModRM, SIB and displacement if used as ModRM
    } lane_info_t;

    typedef lane_info_t [WINDOW_BYTES-1:0] lane_vec_t;

endpackage

// ===== hw/rtl/ild_lane.sv =====
module ild_lane (
    input  logic [7:0]         code_byte,
    output ild_pkg::lane_info_t info
);
    import ild_pkg::*;

    logic [1:0] mod_f;
    logic [2:0] rm_f;
    logic [2:0] span;

    assign mod_f = code_byte[7:6];
    assign rm_f  = code_byte[2:0];

    always_comb
    begin
        span = 3'd1;
        if (mod_f != MOD_REG && rm_f == RM_SIB)
        begin
            span = span + 3'd1;
        end
        if (mod_f == MOD_DISP8)
        begin
            span = span + 3'd1;
        end
        else if (mod_f == MOD_DISP32 || (mod_f == MOD_INDIRECT && rm_f == RM_DISP32))
        begin
            span = span + 3'd4;
        end
    end

    always_comb
    begin
        info.pfx = (code_byte == PFX_OPSIZE) || (code_byte == PFX_REPNE) ||
                   (code_byte == PFX_REP) || (code_byte == PFX_ES) ||
                   (code_byte == PFX_CS) || (code_byte == PFX_SS) ||
                   (code_byte == PFX_DS) || (code_byte == PFX_FS) ||
                   (code_byte == PFX_GS);
        info.rex  = (code_byte[7:4] == REX_BASE[7:4]);
        info.esc  = (code_byte == OP_ESCAPE);
        info.c6   = (code_byte == OP_MOV_C6);
        info.span = span;
        info.fast     = 1'b1;
        info.fast_add = 3'd0;
        if (code_byte[7:3] == OP_MOV_IMM[7:3])
        begin
            info.fast_add = 3'd4;
        end
        else if (code_byte[7:4] == OP_PUSH_POP[7:4] || code_byte == OP_RET ||
                 code_byte == OP_RETF || code_byte == OP_INT3 || code_byte == OP_NOP)
        begin
            info.fast_add = 3'd0;
        end
        else if (code_byte == OP_CALL || code_byte == OP_JMP32)
        begin
            info.fast_add = 3'd4;
        end
        else if (code_byte == OP_JMP8 || code_byte[7:4] == OP_JCC8[7:4])
        begin
            info.fast_add = 3'd1;
        end
        else
        begin
            info.fast = 1'b0;
        end
        if (code_byte == OP_IMUL32 || code_byte == OP_GRP32 || code_byte == OP_MOV_C7)
        begin
            info.imm_add = 3'd4;
        end
        else if (code_byte == OP_IMUL8 || code_byte == OP_GRP8)
        begin
            info.imm_add = 3'd1;
        end
        else
        begin
            info.imm_add = 3'd0;
        end
    end

endmodule

// ===== hw/rtl/ild_merge.sv =====
module ild_merge (
    input  ild_pkg::lane_vec_t           lanes,
    input  logic [ild_pkg::WIN_W-1:0]    win,
    output logic [ild_pkg::LEN_W-1:0]    length
);
    import ild_pkg::*;

    // Picks the lane at a computed position; positions past the lanes read as zero.
    function automatic lane_info_t pick(lane_vec_t lv, logic [POS_W-1:0] idx);
        lane_info_t r;
        r = '0;
        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            if (idx == POS_W'(k))
            begin
                r = lv[k];
            end
        end
        return r;
    endfunction

    logic [POS_W-1:0] win_x;
    logic [POS_W-1:0] first_op;
    logic [POS_W-1:0] op_pos;
    logic [POS_W-1:0] after_op;
    logic [POS_W-1:0] modrm_pos;
    logic [POS_W-1:0] total;
    lane_info_t       at_first;
    lane_info_t       op_lane;
    lane_info_t       modrm_lane;

    assign win_x = POS_W'(win);

    // First byte of the window that is not a legacy prefix.
    always_comb
    begin
        first_op = win_x;
        for (int k = WINDOW_BYTES - 1; k >= 0; k--)
        begin
            if (POS_W'(k) < win_x && !lanes[k].pfx)
            begin
                first_op = POS_W'(k);
            end
        end
    end

    assign at_first  = pick(lanes, first_op);
    assign op_pos    = (first_op < win_x && at_first.rex) ? first_op + POS_W'(1) : first_op;
    assign op_lane   = pick(lanes, op_pos);
    assign after_op  = op_pos + POS_W'(1);
    assign modrm_pos = op_lane.esc ? op_pos + POS_W'(2) : after_op;
    assign modrm_lane = pick(lanes, modrm_pos);

    always_comb
    begin
        total  = '0;
        length = '0;
        if (win_x == '0 || op_pos >= win_x)
        begin
            length = '0;
        end
        else if (op_lane.esc && after_op >= win_x)
        begin
            length = '0;
        end
        else if (!op_lane.esc && op_lane.fast)
        begin
            total  = after_op + POS_W'(op_lane.fast_add);
            length = total[LEN_W-1:0];
        end
        else if (modrm_pos >= win_x)
        begin
            length = '0;
        end
        else if (!op_lane.esc && op_lane.c6)
        begin
            total  = modrm_pos + POS_W'(modrm_lane.span) + POS_W'(1);
            length = total[LEN_W-1:0];
        end
        else
        begin
            total = modrm_pos + POS_W'(modrm_lane.span);
            if (!op_lane.esc)
            begin
                total = total + POS_W'(op_lane.imm_add);
            end
            length = (total <= win_x) ? total[LEN_W-1:0] : '0;
        end
    end

endmodule

// ===== hw/rtl/x86_instruction_length_decoder_unit.sv =====
// Channel  Handshake          Payload
// -------  -----------------  ------------------------------------------
// in       in_valid/in_ready  bytes_low[63:0], bytes_high[55:0], window_length[3:0]
// out      out_valid/out_ready instr_length[4:0]
//
// Each transaction passes two registers: the lane register captures the per-byte
// classification when the input is accepted, and the output register then takes the
// merged length once it is empty or being drained; out_valid rises when it loads. A new
// transaction can be taken every cycle while the output is not stalled.
// An asynchronous active-low reset empties both stages; no payload is cleared.
// When out_ready is held low the output register holds its result, the lane
// register fills behind it, and then in_ready drops until the output is taken.
module x86_instruction_length_decoder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [63:0]                  bytes_low,
    input  logic [55:0]                  bytes_high,
    input  logic [ild_pkg::WIN_W-1:0]    window_length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ild_pkg::LEN_W-1:0]    instr_length
);
    import ild_pkg::*;

    logic [8*PORT_BYTES-1:0] window;
    lane_vec_t               lanes;
    logic [WIN_W-1:0]        win_sat;

    lane_vec_t               lanes_reg;
    logic [WIN_W-1:0]        win_reg;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s2_valid_reg;
    logic                    s2_valid_next;
    logic [LEN_W-1:0]        length_reg;
    logic [LEN_W-1:0]        merged_length;
    logic                    s2_load;
    logic                    s1_load;

    assign window = {bytes_high, bytes_low};

    // A count past the window width is taken as a full window.
    assign win_sat = (window_length > WIN_W'(WINDOW_BYTES)) ? WIN_W'(WINDOW_BYTES)
                                                            : window_length;

    // One classification lane per window byte; each lane knows what its byte would
    // mean as a prefix, REX, escape, opcode or ModRM, and the merge picks the role.
    for (genvar g = 0; g < WINDOW_BYTES; g++)
    begin : g_lane
        ild_lane u_lane (
            .code_byte (window[8*g +: 8]),
            .info      (lanes[g])
        );
    end

    ild_merge u_merge (
        .lanes  (lanes_reg),
        .win    (win_reg),
        .length (merged_length)
    );

    // The output register takes a new result when it is empty or being drained;
    // the lane register moves on when its contents go to the output register.
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            lanes_reg <= lanes;
            win_reg   <= win_sat;
        end
        if (s2_load)
        begin
            length_reg <= merged_length;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign instr_length = length_reg;

endmodule

// ===== hw/rtl/ild_checker.sv =====
module ild_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [ild_pkg::WIN_W-1:0] window_length,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [ild_pkg::LEN_W-1:0] instr_length
);
    import ild_pkg::*;

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(instr_length))
    else $error("stalled result changed");

    // No instruction is longer than 21 bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> instr_length <= LEN_W'(21))
    else $error("length out of range");

    // Input back-pressure only comes from a full output stalled downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

    // An empty window reaching the output on the shortest path decodes to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && window_length == '0 && !out_valid |=>
        ##1 (out_valid && !$past(out_valid)) |-> instr_length == '0)
    else $error("empty window gave a length");

endmodule

bind x86_instruction_length_decoder_unit ild_checker u_ild_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .window_length (window_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .instr_length  (instr_length)
);

// ===== test/x86_instruction_length_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

// This bench checks the length decoder against its own model of the decode rules.
// A driver feeds code windows from a queue. A monitor compares every result with
// the oldest predicted length.
module x86_instruction_length_decoder_unit_tb;

    import ild_pkg::*;

    localparam realtime CLK_PERIOD     = 10.0;
    localparam int      RESET_CYCLES   = 9;
    localparam int      RANDOM_ITEMS   = 2000;
    localparam int      TAIL_ITEMS     = 150;   // last stretch with no idling
    localparam int      DRAIN_CYCLES   = 10;    // ample for the two stages to empty
    localparam int      WATCHDOG_LIMIT = 1000;

    // One input transaction. A window marked drain_first is held back until
    // every earlier result has come out.
    typedef struct {
        logic [63:0]      lo;
        logic [55:0]      hi;
        logic [WIN_W-1:0] win;
        logic             drain_first;
    } code_window_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [63:0]          bytes_low     = '0;
    logic [55:0]          bytes_high    = '0;
    logic [WIN_W-1:0]     window_length = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [LEN_W-1:0]     instr_length;

    code_window_t         pending_windows[$];
    logic [LEN_W-1:0]     expected_lengths[$];

    int                   accepted_count   = 0;
    int                   result_count     = 0;
    int                   undecodable_count = 0;
    int                   longest_length   = 0;
    int                   error_count      = 0;
    int                   sender_gap       = 0;
    int                   receiver_stall   = 0;
    int                   idle_cycles      = 0;
    logic                 tail_phase       = 1'b0;

    x86_instruction_length_decoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .bytes_low     (bytes_low),
        .bytes_high    (bytes_high),
        .window_length (window_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .instr_length  (instr_length)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic is_legacy_prefix(logic [7:0] b);
        case (b)
            PFX_OPSIZE, PFX_REPNE, PFX_REP, PFX_ES, PFX_CS,
            PFX_SS, PFX_DS, PFX_FS, PFX_GS: return 1'b1;
            default:                        return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_byte(int sel);
        case (sel)
            0:       return PFX_OPSIZE;
            1:       return PFX_REPNE;
            2:       return PFX_REP;
            3:       return PFX_ES;
            4:       return PFX_CS;
            5:       return PFX_SS;
            6:       return PFX_DS;
            7:       return PFX_FS;
            default: return PFX_GS;
        endcase
    endfunction

    // Bytes taken by ModRM together with its SIB byte and displacement.
    function automatic int operand_span(logic [7:0] modrm);
        int n;
        n = 1;
        if (modrm[7:6] != MOD_REG && modrm[2:0] == RM_SIB)
            n += 1;
        if (modrm[7:6] == MOD_DISP8)
            n += 1;
        else if (modrm[7:6] == MOD_DISP32 ||
                 (modrm[7:6] == MOD_INDIRECT && modrm[2:0] == RM_DISP32))
            n += 4;
        return n;
    endfunction

    // Length of the first instruction in the window, zero when it is cut off
    // or cannot be decoded.
    function automatic logic [LEN_W-1:0] predict_length(logic [63:0] lo, logic [55:0] hi,
                                                        logic [WIN_W-1:0] win_in);
        logic [7:0] code [PORT_BYTES];
        logic [7:0] op;
        logic       escaped;
        int         win;
        int         pos;
        for (int k = 0; k < 8; k++)
            code[k] = lo[8*k +: 8];
        for (int k = 0; k < 7; k++)
            code[8+k] = hi[8*k +: 8];
        win = win_in;
        if (win > WINDOW_BYTES)
            win = WINDOW_BYTES;
        if (win == 0)
            return '0;

        pos = 0;
        while (pos < win && is_legacy_prefix(code[pos]))
            pos++;
        if (pos < win && code[pos][7:4] == REX_BASE[7:4])
            pos++;
        if (pos >= win)
            return '0;

        op = code[pos];
        pos++;
        escaped = 1'b0;
        if (op == OP_ESCAPE)
        begin
            if (pos >= win)
                return '0;
            op = code[pos];
            pos++;
            escaped = 1'b1;
        end

        // The fast paths report their length without looking at the window.
        if (!escaped)
        begin
            if (op[7:3] == OP_MOV_IMM[7:3])
                return LEN_W'(pos + 4);
            if (op[7:4] == OP_PUSH_POP[7:4])
                return LEN_W'(pos);
            if (op == OP_RET || op == OP_RETF || op == OP_INT3 || op == OP_NOP)
                return LEN_W'(pos);
            if (op == OP_CALL || op == OP_JMP32)
                return LEN_W'(pos + 4);
            if (op == OP_JMP8 || op[7:4] == OP_JCC8[7:4])
                return LEN_W'(pos + 1);
            if (op == OP_MOV_C6)
            begin
                if (pos >= win)
                    return '0;
                return LEN_W'(pos + operand_span(code[pos]) + 1);
            end
        end

        if (pos >= win)
            return '0;
        pos += operand_span(code[pos]);
        if (!escaped)
        begin
            if (op == OP_IMUL32 || op == OP_GRP32 || op == OP_MOV_C7)
                pos += 4;
            else if (op == OP_IMUL8 || op == OP_GRP8)
                pos += 1;
        end
        return (pos <= win) ? LEN_W'(pos) : '0;
    endfunction

    task automatic queue_window(logic [63:0] lo, logic [55:0] hi, logic [WIN_W-1:0] win);
        code_window_t item;
        item.lo          = lo;
        item.hi          = hi;
        item.win         = win;
        item.drain_first = 1'b0;
        pending_windows.insert(pending_windows.size(), item);
    endtask

    // Builds a window that mostly starts with a plausible instruction: prefixes,
    // an optional REX byte, an opcode from one of the decode families, and random
    // operand bytes. The window length usually sits on or just below the length
    // of that instruction so that truncation is hit often.
    function automatic code_window_t random_window();
        logic [7:0]   code [PORT_BYTES];
        code_window_t item;
        int           pos;
        int           n_pfx;
        int           full_len;
        int           pick;
        for (int k = 0; k < PORT_BYTES; k++)
            code[k] = 8'($urandom_range(0, 255));
        pos = 0;
        if ($urandom_range(0, 7) != 0)
        begin
            n_pfx = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 14)
                                                 : $urandom_range(0, 3);
            for (int k = 0; k < n_pfx; k++)
            begin
                code[pos] = prefix_byte($urandom_range(0, 8));
                pos++;
            end
            if ($urandom_range(0, 2) == 0 && pos < PORT_BYTES)
            begin
                code[pos] = REX_BASE | 8'($urandom_range(0, 15));
                pos++;
            end
            if (pos < PORT_BYTES)
            begin
                case ($urandom_range(0, 9))
                    0: code[pos] = OP_ESCAPE;
                    1: code[pos] = OP_MOV_IMM | 8'($urandom_range(0, 7));
                    2: code[pos] = OP_PUSH_POP | 8'($urandom_range(0, 15));
                    3:
                    begin
                        pick = $urandom_range(0, 3);
                        code[pos] = (pick == 0) ? OP_RET : (pick == 1) ? OP_RETF :
                                    (pick == 2) ? OP_INT3 : OP_NOP;
                    end
                    4: code[pos] = $urandom_range(0, 1) ? OP_CALL : OP_JMP32;
                    5: code[pos] = $urandom_range(0, 1) ? OP_JMP8
                                                        : (OP_JCC8 | 8'($urandom_range(0, 15)));
                    6: code[pos] = OP_MOV_C6;
                    7:
                    begin
                        pick = $urandom_range(0, 4);
                        code[pos] = (pick == 0) ? OP_IMUL32 : (pick == 1) ? OP_IMUL8 :
                                    (pick == 2) ? OP_GRP32 : (pick == 3) ? OP_GRP8 : OP_MOV_C7;
                    end
                    default: ;  // keep the random byte as a general-path opcode
                endcase
            end
        end
        for (int k = 0; k < 8; k++)
            item.lo[8*k +: 8] = code[k];
        for (int k = 0; k < 7; k++)
            item.hi[8*k +: 8] = code[8+k];
        item.drain_first = 1'b0;

        full_len = int'(predict_length(item.lo, item.hi, WIN_W'(PORT_BYTES)));
        pick = $urandom_range(0, 7);
        if (pick < 5 && full_len >= 1 && full_len <= PORT_BYTES)
            item.win = WIN_W'(full_len);
        else if (pick == 5 && full_len >= 2 && full_len <= PORT_BYTES)
            item.win = WIN_W'(full_len - 1);
        else
            item.win = WIN_W'($urandom_range(0, 15));
        return item;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on result %0d: %s, got %0d, expected %0d",
                 $realtime, result_count, what, got, want);
        error_count++;
    endtask

    // Driver. A new window is presented only when the previous transaction has
    // been accepted or none is pending, so valid and the payload stay put while
    // the decoder holds in_ready low.
    always @(posedge clk or negedge rst_n)
    begin : drive_windows
        code_window_t     item;
        logic [LEN_W-1:0] length;
        int               accepted_now;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            sender_gap     <= 0;
            accepted_count <= 0;
            tail_phase     <= 1'b0;
        end
        else
        begin
            accepted_now = accepted_count;
            if (in_valid && in_ready)
            begin
                length = predict_length(bytes_low, bytes_high, window_length);
                expected_lengths.insert(expected_lengths.size(), length);
                accepted_now = accepted_count + 1;
                if (length == 0)
                    undecodable_count <= undecodable_count + 1;
                if (int'(length) > longest_length)
                    longest_length <= int'(length);
            end
            accepted_count <= accepted_now;
            tail_phase     <= (pending_windows.size() < TAIL_ITEMS);

            if (!in_valid || in_ready)
            begin
                if (sender_gap > 0)
                begin
                    in_valid   <= 1'b0;
                    sender_gap <= sender_gap - 1;
                end
                else if (pending_windows.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_windows[0].drain_first && accepted_now != result_count)
                    in_valid <= 1'b0;
                else
                begin
                    item = pending_windows.pop_front();
                    bytes_low     <= item.lo;
                    bytes_high    <= item.hi;
                    window_length <= item.win;
                    in_valid      <= 1'b1;
                    if (!tail_phase && $urandom_range(0, 6) == 0)
                        sender_gap <= $urandom_range(1, 5);
                end
            end
        end
    end

    // Monitor. Each accepted result is matched against the oldest prediction,
    // and out_ready is dropped in short random bursts outside the tail.
    always @(posedge clk or negedge rst_n)
    begin : check_lengths
        logic [LEN_W-1:0] want;
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            receiver_stall <= 0;
            result_count   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_lengths.size() == 0)
                    report_mismatch("result with no transaction waiting",
                                    int'(instr_length), 0);
                else
                begin
                    want = expected_lengths.pop_front();
                    if (instr_length !== want)
                        report_mismatch("instr_length", int'(instr_length), int'(want));
                end
            end

            if (receiver_stall > 0)
            begin
                out_ready      <= 1'b0;
                receiver_stall <= receiver_stall - 1;
            end
            else if (!tail_phase && $urandom_range(0, 5) == 0)
            begin
                out_ready      <= 1'b0;
                receiver_stall <= $urandom_range(0, 4);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // The watchdog counts cycles in which neither channel completes a
    // transaction, which covers a hung decoder and a lost result alike.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        code_window_t item;

        // Empty window, and windows made only of prefixes or prefixes with REX.
        queue_window(64'hDEADBEEF_CAFEF00D, 56'h123456_789ABC, 4'd0);
        queue_window(64'h66666666_66666666, 56'h666666_66666666, 4'd15);
        queue_window(64'hF3F3F3F3_F3F3F3F3, 56'h48F3F3_F3F3F3F3, 4'd15);
        // An escape as the last byte of the window, then a complete escaped opcode.
        queue_window(64'h00000000_00000F66, 56'h0, 4'd2);
        queue_window(64'h00000000_00C0AF0F, 56'h0, 4'd3);
        // Fast paths, two of them with a window shorter than their length.
        queue_window(64'h00000000_000000B8, 56'h0, 4'd1);
        queue_window(64'hFFFFFFFF_FFFFFF57, 56'hFFFFFF_FFFFFFFF, 4'd1);
        queue_window(64'h00000000_00005F41, 56'h0, 4'd2);
        queue_window(64'h00000000_000000C3, 56'h0, 4'd1);
        queue_window(64'h00000000_000000CB, 56'h0, 4'd1);
        queue_window(64'h00000000_000000CC, 56'h0, 4'd1);
        queue_window(64'hFFFFFFFF_FFFFFF90, 56'hFFFFFF_FFFFFFFF, 4'd15);
        queue_window(64'h00000000_000000E8, 56'h0, 4'd1);
        queue_window(64'h00000000_000010E9, 56'h0, 4'd15);
        queue_window(64'h00000000_000000EB, 56'h0, 4'd2);
        queue_window(64'h00000000_00000074, 56'h0, 4'd2);
        // C6 without its ModRM byte, and the longest length the decoder can give.
        queue_window(64'h00000000_000000C6, 56'h0, 4'd1);
        queue_window(64'h2E2E2E2E_2E2E2E2E, 56'h84C62E_2E2E2E2E, 4'd15);
        // General path with displacement and immediates, complete and cut short.
        queue_window(64'h11223344_55660581, 56'h00000000_00AABB, 4'd10);
        queue_window(64'h11223344_55660581, 56'h00000000_00AABB, 4'd9);
        queue_window(64'h00000000_0005C86B, 56'h0, 4'd3);
        queue_window(64'h00007856_3412C069, 56'h0, 4'd6);
        queue_window(64'hDDCCBBAA_082444C7, 56'h0, 4'd8);
        queue_window(64'h00000000_0001C083, 56'h0, 4'd2);
        queue_window(64'h00000000_00000001, 56'h0, 4'd1);
        // All-zero and all-one windows at full length.
        queue_window(64'h0, 56'h0, 4'd15);
        queue_window(64'hFFFFFFFF_FFFFFFFF, 56'hFFFFFF_FFFFFFFF, 4'd15);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            item = random_window();
            // Let the pipeline drain completely right after the directed part
            // and once more in the middle of the random part.
            item.drain_first = (n == 0 || n == RANDOM_ITEMS / 2);
            pending_windows.insert(pending_windows.size(), item);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_windows.size() != 0 || in_valid)
            @(posedge clk);
        while (result_count != accepted_count)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d code windows: prefixes, REX, escapes, every fast path and",
                 accepted_count);
        $display("the general path; %0d gave zero, the longest length was %0d.",
                 undecodable_count, longest_length);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
